[sv/tld_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tld_pkg
// Types, codes and pointer helpers for the tty line discipline.
// ----------------------------------------------------------------------------
package tld_pkg;

  localparam int unsigned StoreDepth = 64;
  localparam int unsigned PtrW       = $clog2(StoreDepth);
  localparam int unsigned FillW      = $clog2(StoreDepth + 1);

  typedef logic [PtrW-1:0]  ptr_t;
  typedef logic [FillW-1:0] fill_t;

  localparam logic [7:0] ChBs     = 8'h08;
  localparam logic [7:0] ChLf     = 8'h0A;
  localparam logic [7:0] ChCr     = 8'h0D;
  localparam logic [7:0] ChCaret  = 8'h5E;
  localparam logic [7:0] ChUpperC = 8'h43;

  // control characters used as register reset values
  localparam logic [7:0] CtrlC = 8'h03;
  localparam logic [7:0] CtrlU = 8'h15;
  localparam logic [7:0] CtrlL = 8'h0C;
  localparam logic [7:0] CtrlH = 8'h08;

  localparam logic [7:0] TokMax = 8'hFF;

  typedef enum logic [1:0] {
    KindEcho,
    KindData,
    KindSignal,
    KindStatus
  } kind_e;

  typedef enum logic [1:0] {
    StOk,
    StFull,
    StNoLine,
    StEmpty
  } status_e;

  typedef enum logic [2:0] {
    CfgCanon,
    CfgSignal,
    CfgEcho,
    CfgIntrChar,
    CfgKillChar,
    CfgClearChar,
    CfgEraseChar,
    CfgGroup
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ClsErase,
    ClsIntr,
    ClsKill,
    ClsNewline,
    ClsPlain
  } key_class_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ERASE,
    S_READ,
    S_RD_C,
    S_RD_DEL,
    S_RD_NL,
    S_DONE
  } state_e;

  function automatic ptr_t ptr_next(ptr_t p);
    if (p == ptr_t'(StoreDepth - 1)) begin
      return '0;
    end
    return p + ptr_t'(1);
  endfunction

  function automatic ptr_t ptr_prev(ptr_t p);
    if (p == '0) begin
      return ptr_t'(StoreDepth - 1);
    end
    return p - ptr_t'(1);
  endfunction

endpackage

[sv/tty_line_discipline.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tty_line_discipline
// Canonical terminal line discipline over a ring line store held in one
// synchronous memory.
// ----------------------------------------------------------------------------
//  channel   handshake                    payload
//  item      start & !busy                mode, key_char, begin_read, last_wanted
//  result    res_strobe_o (one cycle)     kind, char_out, signal_group, status,
//                                         read_end, last
//  config    cfg_valid_i & cfg_ready_o    cfg_index_i, cfg_data_i
//
//  a stored keystroke goes from idle straight to the done state; an erase,
//  kill or clear on a non-empty store passes through the erase state, where
//  a kill or clear repeats it, one store read per cycle, up to a newline.
//  a read without data goes to done, else via read, optional ^C, data, newline.
//  results leave one per cycle through an output register; busy is high from
//  the cycle after acceptance and drops in the cycle that shows the last beat.
//  reset empties the store by clearing the pointers and the fill count.
// ----------------------------------------------------------------------------
module tty_line_discipline (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        mode_i,
  input  logic [7:0]  key_char_i,
  input  logic        begin_read_i,
  input  logic        last_wanted_i,
  output logic        res_strobe_o,
  output logic [1:0]  kind_o,
  output logic [7:0]  char_out_o,
  output logic [15:0] signal_group_o,
  output logic [1:0]  status_o,
  output logic        read_end_o,
  output logic        last_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);
  import tld_pkg::*;

  state_e state_q, state_d;

  logic        canon_q, sig_q, echo_q;
  logic [7:0]  intr_q, kill_q, clear_q, erase_q;
  logic [15:0] group_q;

  ptr_t  wp_q, wp_d, rp_q, rp_d;
  fill_t fill_q, fill_d;
  logic [7:0] tok_q, tok_d;

  status_e    status_q, status_d;
  logic       rend_q, rend_d;
  key_class_e item_cls_q, item_cls_d, cls_w;
  logic [7:0] item_char_q, item_char_d;
  logic       item_lastw_q, item_lastw_d;
  logic [7:0] d_q, d_d;

  logic        pend_valid_q, pend_valid_d;
  kind_e       pend_kind_q, pend_kind_d;
  logic [7:0]  pend_char_q, pend_char_d;
  logic [15:0] pend_grp_q, pend_grp_d;

  logic        strobe_q, strobe_d;
  kind_e       okind_q, okind_d;
  logic [7:0]  ochar_q, ochar_d;
  logic [15:0] ogrp_q, ogrp_d;
  logic [1:0]  ostat_q, ostat_d;
  logic        orend_q, orend_d;
  logic        olast_q, olast_d;

  logic [7:0] line_store_q [StoreDepth];
  logic [7:0] mem_rdata_q;
  logic       mem_we;
  ptr_t       mem_waddr, mem_raddr;
  logic [7:0] mem_wdata;

  logic accept_w, erasable_w, kill_more_w, read_int_w;

  assign accept_w    = start && !busy;
  assign busy        = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;

  always_comb begin
    priority if (canon_q && (key_char_i == erase_q || key_char_i == ChBs)) begin
      cls_w = ClsErase;
    end else if (sig_q && key_char_i == intr_q) begin
      cls_w = ClsIntr;
    end else if (key_char_i == kill_q || key_char_i == clear_q) begin
      cls_w = ClsKill;
    end else if (key_char_i == ChLf || key_char_i == ChCr) begin
      cls_w = ClsNewline;
    end else begin
      cls_w = ClsPlain;
    end
  end

  assign erasable_w  = (mem_rdata_q != ChLf);
  assign kill_more_w = (item_cls_q == ClsKill) && erasable_w && (fill_q != fill_t'(1));
  assign read_int_w  = (mem_rdata_q == intr_q) && echo_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept_w) begin
          if (!mode_i) begin
            if ((cls_w == ClsErase || cls_w == ClsKill) && fill_q != '0) begin
              state_d = S_ERASE;
            end else begin
              state_d = S_DONE;
            end
          end else if (!(begin_read_i && tok_q == '0) && fill_q != '0) begin
            state_d = S_READ;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_ERASE:  state_d = kill_more_w ? S_ERASE : S_DONE;
      S_READ:   state_d = read_int_w ? S_RD_C : S_RD_DEL;
      S_RD_C:   state_d = S_RD_DEL;
      S_RD_DEL: state_d = S_RD_NL;
      S_RD_NL:  state_d = S_DONE;
      S_DONE:   state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // datapath and result sequencing
  always_comb begin
    logic       do_push;
    logic       push_tok;
    logic [7:0] push_char;
    ptr_t       wp_base;
    fill_t      fill_base;
    logic       prod;
    kind_e      prod_kind;
    logic [7:0] prod_char;
    logic [15:0] prod_grp;
    logic [7:0] dd;

    do_push   = 1'b0;
    push_tok  = 1'b0;
    push_char = item_char_q;
    wp_base   = wp_q;
    fill_base = fill_q;
    prod      = 1'b0;
    prod_kind = KindEcho;
    prod_char = '0;
    prod_grp  = '0;
    dd        = mem_rdata_q;

    wp_d         = wp_q;
    rp_d         = rp_q;
    fill_d       = fill_q;
    tok_d        = tok_q;
    status_d     = status_q;
    rend_d       = rend_q;
    item_cls_d   = item_cls_q;
    item_char_d  = item_char_q;
    item_lastw_d = item_lastw_q;
    d_d          = d_q;
    mem_we       = 1'b0;
    mem_waddr    = wp_q;
    mem_wdata    = item_char_q;
    mem_raddr    = rp_q;

    unique case (state_q)
      S_IDLE: begin
        if (accept_w) begin
          item_cls_d   = cls_w;
          item_char_d  = key_char_i;
          item_lastw_d = last_wanted_i;
          status_d     = StOk;
          rend_d       = 1'b0;
          if (!mode_i) begin
            push_char = key_char_i;
            unique case (cls_w)
              ClsErase: begin
                mem_raddr = ptr_prev(wp_q);
              end
              ClsKill: begin
                mem_raddr = ptr_prev(wp_q);
                if (fill_q == '0 && key_char_i == clear_q) begin
                  do_push  = 1'b1;
                  push_tok = 1'b1;
                end
              end
              ClsIntr: begin
                do_push  = 1'b1;
                push_tok = 1'b1;
                if (group_q != '0) begin
                  prod      = 1'b1;
                  prod_kind = KindSignal;
                  prod_grp  = group_q;
                end
              end
              ClsNewline: begin
                do_push   = 1'b1;
                push_tok  = 1'b1;
                push_char = ChLf;
              end
              ClsPlain: begin
                do_push = 1'b1;
                if (fill_q != fill_t'(StoreDepth) && echo_q) begin
                  prod      = 1'b1;
                  prod_char = key_char_i;
                end
              end
              default: ;
            endcase
          end else if (begin_read_i && tok_q == '0) begin
            status_d = StNoLine;
            rend_d   = 1'b1;
          end else begin
            if (begin_read_i) begin
              tok_d = tok_q - 8'd1;
            end
            if (fill_q == '0) begin
              status_d = StEmpty;
              rend_d   = 1'b1;
            end else begin
              mem_raddr = rp_q;
              rp_d      = ptr_next(rp_q);
              fill_d    = fill_q - fill_t'(1);
            end
          end
        end
      end
      S_ERASE: begin
        if (erasable_w) begin
          wp_base   = ptr_prev(wp_q);
          fill_base = fill_q - fill_t'(1);
          if (echo_q) begin
            prod      = 1'b1;
            prod_char = ChBs;
          end
        end
        wp_d      = wp_base;
        fill_d    = fill_base;
        mem_raddr = ptr_prev(wp_base);
        if (item_cls_q == ClsKill && !kill_more_w && item_char_q == clear_q) begin
          do_push  = 1'b1;
          push_tok = 1'b1;
        end
      end
      S_READ: begin
        if (read_int_w) begin
          dd        = ChLf;
          prod      = 1'b1;
          prod_char = ChCaret;
        end
        d_d    = dd;
        rend_d = rend_q | (dd == ChLf) | (dd == clear_q) | item_lastw_q;
      end
      S_RD_C: begin
        prod      = 1'b1;
        prod_char = ChUpperC;
      end
      S_RD_DEL: begin
        prod      = 1'b1;
        prod_kind = KindData;
        prod_char = d_q;
      end
      S_RD_NL: begin
        if (d_q == ChLf && echo_q) begin
          prod      = 1'b1;
          prod_char = ChLf;
        end
      end
      S_DONE: ;
      default: ;
    endcase

    if (do_push) begin
      if (fill_base == fill_t'(StoreDepth)) begin
        status_d = StFull;
      end else begin
        mem_we    = 1'b1;
        mem_waddr = wp_base;
        mem_wdata = push_char;
        wp_d      = ptr_next(wp_base);
        fill_d    = fill_base + fill_t'(1);
        if (push_tok && tok_q != TokMax) begin
          tok_d = tok_q + 8'd1;
        end
      end
    end

    // one beat held back so the final one can carry last
    strobe_d     = 1'b0;
    okind_d      = pend_kind_q;
    ochar_d      = pend_char_q;
    ogrp_d       = pend_grp_q;
    ostat_d      = status_q;
    orend_d      = rend_q;
    olast_d      = 1'b0;
    pend_valid_d = pend_valid_q;
    pend_kind_d  = pend_kind_q;
    pend_char_d  = pend_char_q;
    pend_grp_d   = pend_grp_q;

    if (prod) begin
      strobe_d     = pend_valid_q;
      pend_valid_d = 1'b1;
      pend_kind_d  = prod_kind;
      pend_char_d  = prod_char;
      pend_grp_d   = prod_grp;
    end
    if (state_q == S_DONE) begin
      strobe_d     = 1'b1;
      olast_d      = 1'b1;
      pend_valid_d = 1'b0;
      if (!pend_valid_q) begin
        okind_d = KindStatus;
        ochar_d = '0;
        ogrp_d  = '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      line_store_q[mem_waddr] <= mem_wdata;
    end
    mem_rdata_q <= line_store_q[mem_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      wp_q         <= '0;
      rp_q         <= '0;
      fill_q       <= '0;
      tok_q        <= '0;
      status_q     <= StOk;
      rend_q       <= 1'b0;
      pend_valid_q <= 1'b0;
      strobe_q     <= 1'b0;
      canon_q      <= 1'b1;
      sig_q        <= 1'b1;
      echo_q       <= 1'b1;
      intr_q       <= CtrlC;
      kill_q       <= CtrlU;
      clear_q      <= CtrlL;
      erase_q      <= CtrlH;
      group_q      <= '0;
    end else begin
      state_q      <= state_d;
      wp_q         <= wp_d;
      rp_q         <= rp_d;
      fill_q       <= fill_d;
      tok_q        <= tok_d;
      status_q     <= status_d;
      rend_q       <= rend_d;
      pend_valid_q <= pend_valid_d;
      strobe_q     <= strobe_d;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_idx_e'(cfg_index_i))
          CfgCanon:     canon_q <= cfg_data_i[0];
          CfgSignal:    sig_q   <= cfg_data_i[0];
          CfgEcho:      echo_q  <= cfg_data_i[0];
          CfgIntrChar:  intr_q  <= cfg_data_i[7:0];
          CfgKillChar:  kill_q  <= cfg_data_i[7:0];
          CfgClearChar: clear_q <= cfg_data_i[7:0];
          CfgEraseChar: erase_q <= cfg_data_i[7:0];
          CfgGroup:     group_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    item_cls_q   <= item_cls_d;
    item_char_q  <= item_char_d;
    item_lastw_q <= item_lastw_d;
    d_q          <= d_d;
    pend_kind_q  <= pend_kind_d;
    pend_char_q  <= pend_char_d;
    pend_grp_q   <= pend_grp_d;
    okind_q      <= okind_d;
    ochar_q      <= ochar_d;
    ogrp_q       <= ogrp_d;
    ostat_q      <= ostat_d;
    orend_q      <= orend_d;
    olast_q      <= olast_d;
  end

  assign res_strobe_o   = strobe_q;
  assign kind_o         = okind_q;
  assign char_out_o     = ochar_q;
  assign signal_group_o = ogrp_q;
  assign status_o       = ostat_q;
  assign read_end_o     = orend_q;
  assign last_o         = olast_q;

  a_fill_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= fill_t'(StoreDepth))
    else $error("fill count beyond store depth");

  a_accept_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_w |=> busy)
    else $error("accepted beat did not raise busy");

  a_last_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_strobe_o && last_o) |-> !busy)
    else $error("final beat shown while still busy");

  a_signal_group : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_strobe_o && kind_o == KindSignal) |-> signal_group_o != '0)
    else $error("signal beat with zero group");

  a_pend_empty_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !pend_valid_q)
    else $error("held beat left over in idle");

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the tty line discipline. A queue of keystroke and
// read items feeds a clocked driver; every accepted item runs through an
// in-bench model of the line store, and a clocked monitor compares each
// result beat field by field against the oldest predicted result. The run
// walks through several register settings, with bursts of random idle cycles
// on the item side.
// ----------------------------------------------------------------------------
module tb_top;
  import tld_pkg::*;

  localparam logic ModeKey  = 1'b0;
  localparam logic ModeRead = 1'b1;
  localparam int   MaxBeats = 64;

  typedef struct packed {
    logic       mode;
    logic [7:0] key;
    logic       begin_rd;
    logic       last_w;
  } key_item_t;

  typedef struct {
    kind_e       kind;
    logic [7:0]  ch;
    logic [15:0] grp;
    status_e     st;
    logic        rend;
    logic        last;
  } tty_result_t;

  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        start          = 1'b0;
  logic        busy;
  logic        mode_i         = 1'b0;
  logic [7:0]  key_char_i     = '0;
  logic        begin_read_i   = 1'b0;
  logic        last_wanted_i  = 1'b0;
  logic        res_strobe_o;
  logic [1:0]  kind_o;
  logic [7:0]  char_out_o;
  logic [15:0] signal_group_o;
  logic [1:0]  status_o;
  logic        read_end_o;
  logic        last_o;
  logic        cfg_valid_i    = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i    = '0;
  logic [15:0] cfg_data_i     = '0;

  tty_line_discipline DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .mode_i        (mode_i),
    .key_char_i    (key_char_i),
    .begin_read_i  (begin_read_i),
    .last_wanted_i (last_wanted_i),
    .res_strobe_o  (res_strobe_o),
    .kind_o        (kind_o),
    .char_out_o    (char_out_o),
    .signal_group_o(signal_group_o),
    .status_o      (status_o),
    .read_end_o    (read_end_o),
    .last_o        (last_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #2 clk_i = ~clk_i;

  // line store model
  logic [7:0]  key_buf [StoreDepth];
  ptr_t        head_ptr     = '0;
  ptr_t        tail_ptr     = '0;
  int unsigned buf_fill     = 0;
  logic [7:0]  pending_lines = '0;

  logic        canon_en = 1'b1;
  logic        sig_en   = 1'b1;
  logic        echo_en  = 1'b1;
  logic [7:0]  intr_ch  = CtrlC;
  logic [7:0]  kill_ch  = CtrlU;
  logic [7:0]  clear_ch = CtrlL;
  logic [7:0]  erase_ch = CtrlH;
  logic [15:0] fg_group = '0;

  key_item_t   key_items[$];
  tty_result_t item_beats[$];
  tty_result_t expected_beats[$];

  int idle_pct     = 0;
  int n_items      = 0;
  int n_beats      = 0;
  int n_errors     = 0;
  int phase_items  = 0;

  function automatic ptr_t ring_next(ptr_t p);
    return ptr_t'((int'(p) + 1) % StoreDepth);
  endfunction

  function automatic ptr_t ring_prev(ptr_t p);
    return ptr_t'((int'(p) + StoreDepth - 1) % StoreDepth);
  endfunction

  function automatic bit tail_erasable();
    return buf_fill > 0 && key_buf[ring_prev(head_ptr)] != ChLf;
  endfunction

  function automatic void unput_char();
    head_ptr = ring_prev(head_ptr);
    buf_fill--;
  endfunction

  function automatic bit put_char(logic [7:0] c);
    if (buf_fill >= StoreDepth) return 1'b0;
    key_buf[head_ptr] = c;
    head_ptr = ring_next(head_ptr);
    buf_fill++;
    return 1'b1;
  endfunction

  // stores a line terminator and counts the line
  function automatic status_e put_line_end(logic [7:0] c);
    if (!put_char(c)) return StFull;
    if (pending_lines != TokMax) pending_lines++;
    return StOk;
  endfunction

  function automatic void add_beat(kind_e kind, logic [7:0] ch, logic [15:0] grp);
    tty_result_t r;
    if (item_beats.size() >= MaxBeats) return;
    r.kind = kind;
    r.ch   = ch;
    r.grp  = grp;
    r.st   = StOk;
    r.rend = 1'b0;
    r.last = 1'b0;
    item_beats.push_back(r);
  endfunction

  function automatic void predict_item(key_item_t it);
    logic [7:0] c;
    logic [7:0] d;
    status_e    st;
    logic       rend;
    bit         ok;
    tty_result_t r;
    st   = StOk;
    rend = 1'b0;
    c    = it.key;
    item_beats.delete();
    if (it.mode == ModeKey) begin
      if (canon_en && (c == erase_ch || c == ChBs)) begin
        if (tail_erasable()) begin
          unput_char();
          if (echo_en) add_beat(KindEcho, ChBs, '0);
        end
      end else if (sig_en && c == intr_ch) begin
        st = put_line_end(c);
        if (fg_group != '0) add_beat(KindSignal, '0, fg_group);
      end else if (c == kill_ch || c == clear_ch) begin
        while (tail_erasable()) begin
          unput_char();
          if (echo_en) add_beat(KindEcho, ChBs, '0);
        end
        if (c == clear_ch) st = put_line_end(c);
      end else if (c == ChLf || c == ChCr) begin
        st = put_line_end(ChLf);
      end else if (put_char(c)) begin
        if (echo_en) add_beat(KindEcho, c, '0);
      end else begin
        st = StFull;
      end
    end else begin
      ok = 1'b1;
      if (it.begin_rd) begin
        if (pending_lines == '0) begin
          st   = StNoLine;
          rend = 1'b1;
          ok   = 1'b0;
        end else begin
          pending_lines--;
        end
      end
      if (ok) begin
        if (buf_fill == 0) begin
          st   = StEmpty;
          rend = 1'b1;
        end else begin
          d = key_buf[tail_ptr];
          tail_ptr = ring_next(tail_ptr);
          buf_fill--;
          if (d == intr_ch && echo_en) begin
            add_beat(KindEcho, ChCaret, '0);
            add_beat(KindEcho, ChUpperC, '0);
            d = ChLf;
          end
          add_beat(KindData, d, '0);
          if (d == ChLf) begin
            if (echo_en) add_beat(KindEcho, ChLf, '0);
            rend = 1'b1;
          end
          if (d == clear_ch || it.last_w) rend = 1'b1;
        end
      end
    end
    if (item_beats.size() == 0) add_beat(KindStatus, '0, '0);
    foreach (item_beats[i]) begin
      r      = item_beats[i];
      r.st   = st;
      r.rend = rend;
      r.last = (i == item_beats.size() - 1);
      expected_beats.push_back(r);
    end
  endfunction

  // item driver
  always @(posedge clk_i) begin : item_driver
    key_item_t nxt;
    if (rst_ni) begin
      if (start && !busy) begin
        predict_item('{mode: mode_i, key: key_char_i, begin_rd: begin_read_i,
                       last_w: last_wanted_i});
        n_items++;
      end
      if (!start || !busy) begin
        if (key_items.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
          nxt = key_items.pop_front();
          start         <= 1'b1;
          mode_i        <= nxt.mode;
          key_char_i    <= nxt.key;
          begin_read_i  <= nxt.begin_rd;
          last_wanted_i <= nxt.last_w;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i) begin : result_monitor
    tty_result_t exp_r;
    if (rst_ni && res_strobe_o) begin
      if (expected_beats.size() == 0) begin
        $error("unexpected beat: kind %0d char %0h", kind_o, char_out_o);
        n_errors++;
      end else begin
        exp_r = expected_beats.pop_front();
        n_beats++;
        if (kind_o !== exp_r.kind) begin
          $error("kind: expected %0d, got %0d", exp_r.kind, kind_o);
          n_errors++;
        end
        if (char_out_o !== exp_r.ch) begin
          $error("char_out: expected %0h, got %0h", exp_r.ch, char_out_o);
          n_errors++;
        end
        if (signal_group_o !== exp_r.grp) begin
          $error("signal_group: expected %0h, got %0h", exp_r.grp, signal_group_o);
          n_errors++;
        end
        if (status_o !== exp_r.st) begin
          $error("status: expected %0d, got %0d", exp_r.st, status_o);
          n_errors++;
        end
        if (read_end_o !== exp_r.rend) begin
          $error("read_end: expected %0b, got %0b", exp_r.rend, read_end_o);
          n_errors++;
        end
        if (last_o !== exp_r.last) begin
          $error("last: expected %0b, got %0b", exp_r.last, last_o);
          n_errors++;
        end
      end
    end
  end

  task automatic add_item(logic mode, logic [7:0] key, logic bg, logic lw);
    key_items.push_back('{mode: mode, key: key, begin_rd: bg, last_w: lw});
    phase_items++;
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [15:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CfgCanon:     canon_en = val[0];
      CfgSignal:    sig_en   = val[0];
      CfgEcho:      echo_en  = val[0];
      CfgIntrChar:  intr_ch  = val[7:0];
      CfgKillChar:  kill_ch  = val[7:0];
      CfgClearChar: clear_ch = val[7:0];
      CfgEraseChar: erase_ch = val[7:0];
      CfgGroup:     fg_group = val;
      default: ;
    endcase
  endtask

  task automatic set_all(logic cn, logic sg, logic ec, logic [7:0] ic, logic [7:0] kc,
                         logic [7:0] cc, logic [7:0] erc, logic [15:0] grp);
    write_reg(CfgCanon, 16'(cn));
    write_reg(CfgSignal, 16'(sg));
    write_reg(CfgEcho, 16'(ec));
    write_reg(CfgIntrChar, 16'(ic));
    write_reg(CfgKillChar, 16'(kc));
    write_reg(CfgClearChar, 16'(cc));
    write_reg(CfgEraseChar, 16'(erc));
    write_reg(CfgGroup, grp);
  endtask

  task automatic wait_idle(int settle);
    do @(posedge clk_i);
    while (key_items.size() != 0 || start || busy || expected_beats.size() != 0);
    repeat (settle) @(posedge clk_i);
  endtask

  // typed line with edits, a terminator, then a read call
  task automatic gen_line();
    int n;
    int r;
    int len;
    logic [7:0] c;
    n = $urandom_range(0, 10);
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 10) c = $urandom_range(0, 1) ? erase_ch : ChBs;
      else if (r < 13) c = kill_ch;
      else if (r < 18) c = 8'($urandom_range(0, 255));
      else c = 8'($urandom_range(32, 126));
      add_item(ModeKey, c, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    end
    r = $urandom_range(0, 99);
    if (r < 40) c = ChLf;
    else if (r < 65) c = ChCr;
    else if (r < 85) c = clear_ch;
    else c = intr_ch;
    add_item(ModeKey, c, 1'b0, 1'b0);
    len = $urandom_range(1, n + 3);
    for (int i = 0; i < len; i++) begin
      add_item(ModeRead, 8'($urandom_range(0, 255)), i == 0,
               (i == len - 1) ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 9) == 0));
    end
  endtask

  // drain, overfill past the store size, then erase back
  task automatic gen_flood(logic [7:0] closer);
    for (int i = 0; i < StoreDepth + 2; i++) begin
      add_item(ModeRead, 8'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1)));
    end
    for (int i = 0; i < StoreDepth + 2; i++) begin
      add_item(ModeKey, 8'($urandom_range(32, 126)), 1'b0, 1'b0);
    end
    add_item(ModeKey, intr_ch, 1'b0, 1'b0);
    add_item(ModeKey, closer, 1'b0, 1'b0);
  endtask

  initial begin : stimulus
    int idle_by_phase[7];
    int r;
    idle_by_phase = '{0, 0, 64, 0, 36, 64, 36};
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    for (int p = 0; p < 7; p++) begin
      case (p)
        1: set_all(1'b1, 1'b1, 1'b1, CtrlC, CtrlU, CtrlL, 8'h7F, 16'h1234);
        2: set_all(1'b0, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0000);
        3: set_all(1'b1, 1'b1, 1'b1, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF);
        4: set_all(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)), 8'($urandom_range(0, 31)),
                   8'($urandom_range(0, 31)), 8'($urandom_range(0, 31)),
                   8'($urandom_range(0, 31)), 16'($urandom_range(1, 65535)));
        5: set_all(1'b1, 1'b1, 1'b0, CtrlC, CtrlU, CtrlL, CtrlH,
                   16'($urandom_range(1, 65535)));
        6: set_all(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)), 16'($urandom));
        default: ;
      endcase
      @(negedge clk_i);
      idle_pct = idle_by_phase[p];
      if (p == 0) begin
        // reads with no line and on an empty store, erase with nothing stored
        add_item(ModeRead, 8'hFF, 1'b1, 1'b0);
        add_item(ModeRead, 8'h00, 1'b0, 1'b1);
        add_item(ModeKey, ChBs, 1'b0, 1'b0);
        add_item(ModeKey, "h", 1'b0, 1'b0);
        add_item(ModeKey, "i", 1'b0, 1'b0);
        add_item(ModeKey, ChBs, 1'b0, 1'b0);
        add_item(ModeKey, 8'hFF, 1'b0, 1'b0);
        add_item(ModeKey, 8'h00, 1'b0, 1'b0);
        add_item(ModeKey, CtrlU, 1'b0, 1'b0);
        add_item(ModeKey, "x", 1'b0, 1'b0);
        add_item(ModeKey, ChCr, 1'b0, 1'b0);
        // erase stops at a newline, interrupt with no group
        add_item(ModeKey, ChBs, 1'b0, 1'b0);
        add_item(ModeKey, CtrlC, 1'b0, 1'b0);
        add_item(ModeKey, "y", 1'b0, 1'b0);
        add_item(ModeKey, CtrlL, 1'b0, 1'b0);
        add_item(ModeRead, 8'h00, 1'b1, 1'b0);
        add_item(ModeRead, 8'h00, 1'b0, 1'b0);
        add_item(ModeRead, 8'h00, 1'b1, 1'b0);
        add_item(ModeRead, 8'h00, 1'b1, 1'b0);
        add_item(ModeRead, 8'h00, 1'b1, 1'b1);
        add_item(ModeKey, "a", 1'b0, 1'b0);
        add_item(ModeKey, ChLf, 1'b0, 1'b0);
        add_item(ModeRead, 8'hA5, 1'b1, 1'b1);
        add_item(ModeRead, 8'h5A, 1'b0, 1'b0);
      end
      if (p == 1) gen_flood(kill_ch);
      if (p == 4) gen_flood(clear_ch);
      phase_items = 0;
      while (phase_items < 20) begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          gen_line();
        end else begin
          repeat ($urandom_range(1, 4)) begin
            add_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
          end
        end
      end
      wait_idle(10);
    end
    wait_idle(StoreDepth + 8);
    $display("run covered %0d items and %0d result beats over 7 register settings",
             n_items, n_beats);
    if (n_errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin : watchdog
    #3_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
